/* rtl/tga_dec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_dec_pkg
// Types and constants shared by the TGA true-color stream decoder files.
// ----------------------------------------------------------------------------
package tga_dec_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TYPE     = 2'd1,
    ERR_BPP      = 2'd2,
    ERR_R_TO_L   = 2'd3
  } err_e;

  // header byte positions
  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP      = 5'd16;
  localparam logic [4:0] HDR_ATTR     = 5'd17;

  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;
  localparam int unsigned ATTR_R_TO_L_BIT = 4;  // 0x10
  localparam int unsigned ATTR_T_TO_B_BIT = 5;  // 0x20

  // result word layout
  localparam int unsigned OUT_W = 72;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] row;
    logic [15:0] column;
    logic        has_alpha;
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [1:0]  error_code;
  } result_t;

endpackage

/* rtl/tga_truecolor_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder
// Byte-stream decoder for uncompressed true-color TGA files.
// ----------------------------------------------------------------------------
// Takes one file byte per word and one byte per cycle while the result word
// is not held by a low m_axis_tready_i; an accepted byte passes the input
// register, then the per-byte header/pixel state update into the result
// register. tuser high marks the first byte of a file and restarts the
// parse. Pixel words carry RGB(A), column and destination row with tlast on
// the final pixel; a rejected file gives one word with tuser high and the
// error code, then the block drops bytes until the next first byte.
module tga_truecolor_stream_decoder
  import tga_dec_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // data_byte[7:0]
  input  logic              s_axis_tuser_i,   // first_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // error_code[1:0], red[9:2],
                                              // green[17:10], blue[25:18],
                                              // alpha[33:26], has_alpha[34],
                                              // column[50:35], row[66:51],
                                              // zero pad[71:67]
  output logic              m_axis_tuser_o,   // kind
  output logic              m_axis_tlast_o    // last_pixel
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_first_q;

  // parse state
  phase_e      phase_q, phase_d, phase_eff;
  logic [4:0]  hcnt_q, hcnt_d, hcnt_eff;
  logic [7:0]  id_len_q, id_len_d;
  logic [7:0]  id_rem_q, id_rem_d;
  logic [7:0]  img_type_q, img_type_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  bpp_q, bpp_d;
  logic [7:0]  attr_q, attr_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] hold_q, hold_d;
  logic [15:0] col_q, col_d;
  logic [15:0] frow_q, frow_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    kind_q, kind_d;
  logic    last_q, last_d;

  logic advance, fire, s_accept;
  logic emit, emit_err;
  err_e err;
  logic four, last_byte, col_end, row_end, dims_zero;
  logic [15:0] rowv;

  assign advance  = !out_valid_q || m_axis_tready_i;
  assign fire     = in_valid_q && advance;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign phase_eff = in_first_q ? PH_HEADER : phase_q;
  assign hcnt_eff  = in_first_q ? 5'd0 : hcnt_q;

  assign four      = (bpp_q == BPP_32);
  assign last_byte = (bip_q == (four ? 2'd3 : 2'd2));
  assign col_end   = (col_q == width_q - 16'd1);
  assign row_end   = (frow_q == height_q - 16'd1);
  assign rowv      = attr_q[ATTR_T_TO_B_BIT] ? (height_q - 16'd1 - frow_q) : frow_q;
  assign dims_zero = (width_q == 16'd0) || (height_q == 16'd0);

  always_comb begin
    if (img_type_q != TYPE_TRUECOLOR) begin
      err = ERR_TYPE;
    end else if (bpp_q != BPP_24 && bpp_q != BPP_32) begin
      err = ERR_BPP;
    end else if (in_byte_q[ATTR_R_TO_L_BIT]) begin
      err = ERR_R_TO_L;
    end else begin
      err = ERR_NONE;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      phase_d = phase_eff;
      case (phase_eff)
        PH_HEADER: begin
          if (hcnt_eff == HDR_ATTR) begin
            if (err != ERR_NONE) begin
              phase_d = PH_IDLE;
            end else if (id_len_q != 8'd0) begin
              phase_d = PH_ID;
            end else begin
              phase_d = dims_zero ? PH_IDLE : PH_PIXELS;
            end
          end
        end
        PH_ID: begin
          if (id_rem_q == 8'd1) begin
            phase_d = dims_zero ? PH_IDLE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (last_byte && col_end && row_end) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = phase_eff;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    hcnt_d     = hcnt_q;
    id_len_d   = id_len_q;
    id_rem_d   = id_rem_q;
    img_type_d = img_type_q;
    width_d    = width_q;
    height_d   = height_q;
    bpp_d      = bpp_q;
    attr_d     = attr_q;
    bip_d      = bip_q;
    hold_d     = hold_q;
    col_d      = col_q;
    frow_d     = frow_q;
    emit       = 1'b0;
    emit_err   = 1'b0;
    out_d      = '0;
    kind_d     = 1'b0;
    last_d     = 1'b0;
    if (fire) begin
      hcnt_d = hcnt_eff;
      case (phase_eff)
        PH_HEADER: begin
          hcnt_d = hcnt_eff + 5'd1;
          case (hcnt_eff)
            HDR_ID_LEN:    id_len_d = in_byte_q;
            HDR_TYPE:      img_type_d = in_byte_q;
            HDR_WIDTH_LO:  width_d[7:0] = in_byte_q;
            HDR_WIDTH_HI:  width_d[15:8] = in_byte_q;
            HDR_HEIGHT_LO: height_d[7:0] = in_byte_q;
            HDR_HEIGHT_HI: height_d[15:8] = in_byte_q;
            HDR_BPP:       bpp_d = in_byte_q;
            HDR_ATTR: begin
              attr_d   = in_byte_q;
              id_rem_d = id_len_q;
              bip_d    = 2'd0;
              col_d    = 16'd0;
              frow_d   = 16'd0;
              if (err != ERR_NONE) begin
                emit_err = 1'b1;
              end
            end
            default: hcnt_d = hcnt_eff + 5'd1;
          endcase
        end
        PH_ID: begin
          id_rem_d = id_rem_q - 8'd1;
          bip_d    = 2'd0;
          col_d    = 16'd0;
          frow_d   = 16'd0;
        end
        PH_PIXELS: begin
          if (!last_byte) begin
            case (bip_q)
              2'd0:    hold_d[7:0]   = in_byte_q;
              2'd1:    hold_d[15:8]  = in_byte_q;
              default: hold_d[23:16] = in_byte_q;
            endcase
            bip_d = bip_q + 2'd1;
          end else begin
            emit  = 1'b1;
            bip_d = 2'd0;
            if (!col_end) begin
              col_d = col_q + 16'd1;
            end else if (!row_end) begin
              col_d  = 16'd0;
              frow_d = frow_q + 16'd1;
            end
          end
        end
        default: hcnt_d = hcnt_eff;
      endcase
    end
    if (emit_err) begin
      kind_d           = 1'b1;
      out_d.error_code = err;
    end else if (emit) begin
      out_d.red       = four ? hold_q[23:16] : in_byte_q;
      out_d.green     = hold_q[15:8];
      out_d.blue      = hold_q[7:0];
      out_d.alpha     = four ? in_byte_q : 8'd0;
      out_d.has_alpha = four;
      out_d.column    = col_q;
      out_d.row       = rowv;
      last_d          = col_end && row_end;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit || emit_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      hcnt_q      <= 5'd0;
      id_len_q    <= 8'd0;
      id_rem_q    <= 8'd0;
      img_type_q  <= 8'd0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      bpp_q       <= 8'd0;
      attr_q      <= 8'd0;
      bip_q       <= 2'd0;
      col_q       <= 16'd0;
      frow_q      <= 16'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      hcnt_q      <= hcnt_d;
      id_len_q    <= id_len_d;
      id_rem_q    <= id_rem_d;
      img_type_q  <= img_type_d;
      width_q     <= width_d;
      height_q    <= height_d;
      bpp_q       <= bpp_d;
      attr_q      <= attr_d;
      bip_q       <= bip_d;
      col_q       <= col_d;
      frow_q      <= frow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
    end
    hold_q <= hold_d;
    if (advance) begin
      out_q  <= out_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* rtl/tga_dec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_dec_checker
// Port-level checks for the TGA true-color stream decoder.
// ----------------------------------------------------------------------------
module tga_dec_checker
  import tga_dec_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  input  logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  logic [OUT_W-1:0]  m_axis_tdata_o,
  input  logic              m_axis_tuser_o,
  input  logic              m_axis_tlast_o
);

  // stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // reject word: nonzero code, everything else zero
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[1:0] != ERR_NONE && m_axis_tdata_o[OUT_W-1:2] == '0
      && !m_axis_tlast_o)
    else $error("malformed reject word");

  // pixel word: no error code, zero pad, alpha zero without alpha flag
  a_pix_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[1:0] == ERR_NONE && m_axis_tdata_o[OUT_W-1:67] == '0
      && (m_axis_tdata_o[34] || m_axis_tdata_o[33:26] == 8'd0))
    else $error("malformed pixel word");

  // input never blocked while output side is free
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

bind tga_truecolor_stream_decoder tga_dec_checker u_tga_dec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* verif/tga_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_checker
// Predicts the pixel and reject words of the TGA true-color stream decoder
// from the accepted input bytes and compares every accepted result word,
// field by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tga_pixel_checker
  import tga_dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [7:0]       s_tdata_i,
  input  logic             s_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [OUT_W-1:0] m_tdata_i,
  input  logic             m_tuser_i,
  input  logic             m_tlast_i,
  output int               mismatch_o,
  output int               pending_o
);

  typedef struct packed {
    logic        kind;
    logic [1:0]  code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [15:0] column;
    logic [15:0] row;
    logic        last;
  } tga_word_t;

  tga_word_t   words_due[$];

  phase_e      phase;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_len;
  logic [7:0]  id_left;
  logic [7:0]  img_type;
  logic [15:0] width;
  logic [15:0] height;
  logic [7:0]  depth;
  logic [7:0]  attr;
  logic [1:0]  pix_byte;
  logic [23:0] pix_acc;
  logic [15:0] col_cnt;
  logic [15:0] row_cnt;

  task automatic clear_state();
    phase    = PH_HEADER;
    hdr_pos  = '0;
    id_len   = '0;
    id_left  = '0;
    img_type = '0;
    width    = '0;
    height   = '0;
    depth    = '0;
    attr     = '0;
    pix_byte = '0;
    pix_acc  = '0;
    col_cnt  = '0;
    row_cnt  = '0;
  endtask

  task automatic start_pixels();
    pix_byte = '0;
    pix_acc  = '0;
    col_cnt  = '0;
    row_cnt  = '0;
    phase    = (width == 16'd0 || height == 16'd0) ? PH_IDLE : PH_PIXELS;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic first);
    tga_word_t   w;
    logic [4:0]  pos;
    logic        four;
    logic [1:0]  last_idx;
    logic [15:0] w_max;
    logic [15:0] h_max;
    w = '0;
    if (first) clear_state();
    case (phase)
      PH_HEADER: begin
        pos = hdr_pos;
        hdr_pos = hdr_pos + 5'd1;
        case (pos)
          HDR_ID_LEN:    id_len = b;
          HDR_TYPE:      img_type = b;
          HDR_WIDTH_LO:  width[7:0] = b;
          HDR_WIDTH_HI:  width[15:8] = b;
          HDR_HEIGHT_LO: height[7:0] = b;
          HDR_HEIGHT_HI: height[15:8] = b;
          HDR_BPP:       depth = b;
          HDR_ATTR: begin
            attr = b;
            if (img_type != TYPE_TRUECOLOR) w.code = ERR_TYPE;
            else if (depth != BPP_24 && depth != BPP_32) w.code = ERR_BPP;
            else if (attr[ATTR_R_TO_L_BIT]) w.code = ERR_R_TO_L;
            if (w.code != ERR_NONE) begin
              w.kind = 1'b1;
              words_due.push_back(w);
              phase = PH_IDLE;
            end else if (id_len != 8'd0) begin
              id_left = id_len;
              phase = PH_ID;
            end else begin
              start_pixels();
            end
          end
          default: ;
        endcase
      end
      PH_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) start_pixels();
      end
      PH_PIXELS: begin
        four = (depth == BPP_32);
        last_idx = four ? 2'd3 : 2'd2;
        if (pix_byte < last_idx) begin
          pix_acc[8*pix_byte +: 8] = b;
          pix_byte = pix_byte + 2'd1;
        end else begin
          if (!four) pix_acc[23:16] = b;
          w_max = width - 16'd1;
          h_max = height - 16'd1;
          w.red       = pix_acc[23:16];
          w.green     = pix_acc[15:8];
          w.blue      = pix_acc[7:0];
          w.alpha     = four ? b : 8'd0;
          w.has_alpha = four;
          w.column    = col_cnt;
          w.row       = attr[ATTR_T_TO_B_BIT] ? h_max - row_cnt : row_cnt;
          w.last      = (col_cnt == w_max) && (row_cnt == h_max);
          words_due.push_back(w);
          pix_byte = '0;
          pix_acc  = '0;
          if (w.last) begin
            phase = PH_IDLE;
          end else if (col_cnt == w_max) begin
            col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
          end else begin
            col_cnt = col_cnt + 16'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_o++;
    end
  endfunction

  task automatic check_word();
    result_t   got;
    tga_word_t want;
    got = result_t'(m_tdata_i);
    if (words_due.size() == 0) begin
      $error("result word with no prediction waiting");
      mismatch_o++;
    end else begin
      want = words_due.pop_front();
      check_field("kind", 16'(want.kind), 16'(m_tuser_i));
      check_field("error_code", 16'(want.code), 16'(got.error_code));
      check_field("red", 16'(want.red), 16'(got.red));
      check_field("green", 16'(want.green), 16'(got.green));
      check_field("blue", 16'(want.blue), 16'(got.blue));
      check_field("alpha", 16'(want.alpha), 16'(got.alpha));
      check_field("has_alpha", 16'(want.has_alpha), 16'(got.has_alpha));
      check_field("column", want.column, got.column);
      check_field("row", want.row, got.row);
      check_field("last_pixel", 16'(want.last), 16'(m_tlast_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      words_due.delete();
      mismatch_o = 0;
      pending_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_word();
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tuser_i);
      pending_o = words_due.size();
    end
  end

endmodule

/* verif/tga_truecolor_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder_tb
// Feeds the decoder whole TGA files: directed headers for every reject
// reason, zero sizes, flipped rows, ID fields and mid-file restarts, then
// random files and noise, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tga_truecolor_stream_decoder_tb;
  import tga_dec_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i = '0;
  logic             s_axis_tuser_i = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b1;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tuser_o;
  logic             m_axis_tlast_o;

  int  mismatches;
  int  pending;
  int  file_bytes = 0;
  bit  quiet = 1'b0;
  bit  drained_once = 1'b0;

  always #2 clk_i = ~clk_i;

  tga_truecolor_stream_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  tga_pixel_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_i (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_i (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_i  (m_axis_tdata_o),
    .m_tuser_i  (m_axis_tuser_o),
    .m_tlast_i  (m_axis_tlast_o),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready_i <= quiet || ($urandom_range(0, 99) >= 8);
  end

  task automatic put_byte(input logic [7:0] d, input logic first);
    bit taken;
    while (!quiet && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= first;
    do begin
      @(posedge clk_i);
      taken = s_axis_tready_o;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // cut < 0 sends the whole body; trail bytes follow and are dropped
  task automatic send_tga(input logic [7:0] itype, input logic [7:0] depth,
                          input logic [7:0] attr, input logic [7:0] idlen,
                          input logic [15:0] wd, input logic [15:0] ht,
                          input logic first, input int cut, input int trail);
    logic [7:0] hdr [18];
    longint     body;
    for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom);
    hdr[HDR_ID_LEN]    = idlen;
    hdr[HDR_TYPE]      = itype;
    hdr[HDR_WIDTH_LO]  = wd[7:0];
    hdr[HDR_WIDTH_HI]  = wd[15:8];
    hdr[HDR_HEIGHT_LO] = ht[7:0];
    hdr[HDR_HEIGHT_HI] = ht[15:8];
    hdr[HDR_BPP]       = depth;
    hdr[HDR_ATTR]      = attr;
    for (int i = 0; i < 18; i++) begin
      put_byte(hdr[i], (i == 0) ? first : 1'b0);
      file_bytes++;
    end
    body = 0;
    if (itype == TYPE_TRUECOLOR && (depth == BPP_24 || depth == BPP_32) &&
        !attr[ATTR_R_TO_L_BIT])
      body = longint'(idlen) + longint'(wd) * longint'(ht) * longint'(depth / 8);
    if (cut >= 0 && cut < body) body = cut;
    for (longint n = 0; n < body; n++) begin
      put_byte(8'($urandom), 1'b0);
      file_bytes++;
    end
    for (int n = 0; n < trail; n++) put_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int         pick;
    int         waited;
    logic [7:0] itype;
    logic [7:0] depth;
    logic [15:0] wd;
    logic [15:0] ht;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: no restart flag on the first file, trailing bytes dropped
    send_tga(TYPE_TRUECOLOR, BPP_24, 8'h00, 8'd0, 16'd2, 16'd2, 1'b0, -1, 2);
    send_tga(TYPE_TRUECOLOR, BPP_32, 8'h28, 8'd3, 16'd3, 16'd2, 1'b1, -1, 0);
    send_tga(8'd10, BPP_24, 8'h00, 8'd0, 16'd1, 16'd1, 1'b1, -1, 4);
    send_tga(8'd0, 8'd16, 8'h10, 8'd0, 16'd1, 16'd1, 1'b1, -1, 2);
    send_tga(TYPE_TRUECOLOR, 8'd16, 8'h10, 8'd0, 16'd2, 16'd1, 1'b1, -1, 3);
    send_tga(TYPE_TRUECOLOR, 8'hFF, 8'h00, 8'd0, 16'd2, 16'd1, 1'b1, -1, 0);
    send_tga(TYPE_TRUECOLOR, BPP_32, 8'h10, 8'd0, 16'd1, 16'd1, 1'b1, -1, 2);
    send_tga(TYPE_TRUECOLOR, BPP_24, 8'hFF, 8'd4, 16'd1, 16'd1, 1'b1, -1, 2);
    send_tga(TYPE_TRUECOLOR, BPP_24, 8'h00, 8'd0, 16'd0, 16'd3, 1'b1, -1, 5);
    send_tga(TYPE_TRUECOLOR, BPP_32, 8'h20, 8'd2, 16'd4, 16'd0, 1'b1, -1, 5);
    // widest row, abandoned mid-pixel by the next file
    send_tga(TYPE_TRUECOLOR, BPP_24, 8'h00, 8'd0, 16'hFFFF, 16'd1, 1'b1, 13, 0);
    // tallest flipped image behind the longest ID field
    send_tga(TYPE_TRUECOLOR, BPP_32, 8'h20, 8'hFF, 16'd1, 16'hFFFF, 1'b1, 255 + 12, 0);
    send_tga(TYPE_TRUECOLOR, BPP_32, 8'hEF, 8'd0, 16'd2, 16'd3, 1'b1, -1, 1);
    send_tga(TYPE_TRUECOLOR, BPP_24, 8'h00, 8'd1, 16'd1, 16'd1, 1'b1, -1, 0);

    while (file_bytes < 1700) begin
      if (!drained_once && file_bytes > 900) begin
        s_axis_tvalid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        drained_once = 1'b1;
      end
      quiet = (file_bytes > 1000 && file_bytes < 1300);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        depth = $urandom_range(0, 1) ? BPP_32 : BPP_24;
        send_tga(TYPE_TRUECOLOR, depth, 8'($urandom) & 8'hEF,
                 ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 12)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 5)),
                 $urandom_range(0, 19) != 0,
                 ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) : -1,
                 ($urandom_range(0, 9) < 3) ? int'($urandom_range(1, 4)) : 0);
      end else if (pick < 80) begin
        itype = ($urandom_range(0, 2) == 0) ? 8'($urandom) : TYPE_TRUECOLOR;
        case ($urandom_range(0, 2))
          0:       depth = BPP_24;
          1:       depth = BPP_32;
          default: depth = 8'($urandom);
        endcase
        send_tga(itype, depth, 8'($urandom), 8'($urandom_range(0, 3)),
                 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 1'b1, -1,
                 $urandom_range(0, 6));
      end else if (pick < 87) begin
        wd = 16'($urandom_range(0, 4));
        ht = (wd == 16'd0) ? 16'($urandom) : 16'd0;
        send_tga(TYPE_TRUECOLOR, $urandom_range(0, 1) ? BPP_32 : BPP_24,
                 8'($urandom) & 8'hEF, 8'($urandom_range(0, 2)), wd, ht, 1'b1, -1,
                 $urandom_range(0, 6));
      end else begin
        for (int n = $urandom_range(1, 8); n > 0; n--)
          put_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tga_truecolor_stream_decoder test passed");
    end else begin
      $display("tga_truecolor_stream_decoder test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tga_truecolor_stream_decoder test failed");
    $finish;
  end

endmodule
